@@ src/hangul_bigram_hash_counter_assert.svh @@
// Assertion helpers used by hbc_ctrl.
// Both macros expect aclk and aresetn to be in scope.
`ifndef HANGUL_BIGRAM_HASH_COUNTER_ASSERT_SVH
`define HANGUL_BIGRAM_HASH_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define HBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hbc_pkg.sv @@
// ----------------------------------------------------------------------------
// hbc_pkg
// Types and constants shared by the bigram counter controller and datapath.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int CMD_W   = 1;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 16;
    localparam int KEY_W   = 27;
    localparam int COUNT_W = 32;
    localparam int TOK_W   = 14;
    localparam int CODE_W  = 21;

    localparam int DEF_TABLE_SLOTS        = 65536;
    localparam int DEF_MAX_WORD_SYLLABLES = 256;

    localparam logic [CMD_W-1:0] CMD_FEED = 1'b0;
    localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

    localparam logic [BYTE_W-1:0] NEWLINE    = 8'h0A;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    localparam logic [CODE_W-1:0] SYL_FIRST   = 21'h00AC00;
    localparam logic [CODE_W-1:0] SYL_LAST    = 21'h00D7A3;
    localparam logic [TOK_W-1:0]  START_TOKEN = 14'd11172;
    localparam logic [TOK_W-1:0]  END_TOKEN   = 14'd11173;
    localparam logic [TOK_W-1:0]  TOKEN_BASE  = 14'd11174;

    // Controller states
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_KEY   = 6'b000100,
        S_HASH  = 6'b001000,
        S_READ  = 6'b010000,
        S_CHECK = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;        // zero one table slot
        logic take;         // request accepted this cycle
        logic calc_key;     // form the bigram key
        logic start_probe;  // load home slot
        logic read_mem;     // read the addressed slot
        logic next_probe;   // advance to the following slot
        logic finish;       // update table if needed and load the result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic job_read;     // current request is a slot read
        logic job_bigram;   // current byte produces a bigram
        logic is_read;
        logic hit;
        logic last_probe;
        logic out_free;
    } sts_t;

endpackage

@@ src/hbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbc_ctrl
// Sequencer for table clearing, key formation, probing and result hand-off.
// ----------------------------------------------------------------------------
`include "hangul_bigram_hash_counter_assert.svh"

module hbc_ctrl
    import hbc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (sts.job_read) begin
                        state_next = S_READ;
                    end else if (sts.job_bigram) begin
                        state_next = S_KEY;
                    end
                end
            end
            S_KEY: begin
                cmd.calc_key = 1'b1;
                state_next   = S_HASH;
            end
            S_HASH: begin
                cmd.start_probe = 1'b1;
                state_next      = S_READ;
            end
            S_READ: begin
                cmd.read_mem = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                // hold until the result register can take the new result
                if (sts.is_read || sts.hit || sts.last_probe) begin
                    if (sts.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.next_probe = 1'b1;
                    state_next     = S_READ;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    `HBC_ASSERT_NOW(a_finish_room, cmd.finish, sts.out_free,
        "result loaded while previous result still pending")
    `HBC_ASSERT_NOW(a_probe_skip, cmd.next_probe, !sts.hit && !sts.last_probe,
        "probe advanced past a usable slot or past the table end")
    `HBC_ASSERT_NEXT(a_read_path, cmd.take && sts.job_read, state_reg == S_READ,
        "slot read request did not go straight to the table read")

endmodule

@@ src/hbc_datapath.sv @@
// ----------------------------------------------------------------------------
// hbc_datapath
// UTF-8 decoder, word state, key formation, hash table memory with linear
// probing, and the result register.
// ----------------------------------------------------------------------------
module hbc_datapath
    import hbc_pkg::*;
#(
    parameter int TABLE_SLOTS        = DEF_TABLE_SLOTS,
    parameter int MAX_WORD_SYLLABLES = DEF_MAX_WORD_SYLLABLES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [CMD_W-1:0]   s_command,
    input  logic [BYTE_W-1:0]  s_text_byte,
    input  logic [IDX_W-1:0]   s_slot_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [IDX_W-1:0]   m_slot,
    output logic [KEY_W-1:0]   m_bigram_key,
    output logic [COUNT_W-1:0] m_pair_count,
    output logic               m_new_entry,
    output logic               m_table_full
);

    // TABLE_SLOTS is a power of two
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int WCNT_W = $clog2(MAX_WORD_SYLLABLES + 1);
    localparam int ENT_W  = KEY_W + COUNT_W;
    localparam logic [WCNT_W-1:0] WCNT_MAX = WCNT_W'(MAX_WORD_SYLLABLES);

    // Decoder and word state
    logic [TOK_W-1:0]  prev_tok_reg, prev_tok_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    logic [1:0]        rem_reg, rem_next;
    logic [CODE_W-1:0] acc_reg, acc_next;

    // Job registers
    logic [TOK_W-1:0]  from_reg;
    logic [TOK_W-1:0]  to_reg;
    logic [TOK_W-1:0]  from_next, to_next;
    logic              is_read_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] addr_reg;
    logic [SLOT_W-1:0] home_reg;
    logic [SLOT_W-1:0] probe_reg;
    logic [SLOT_W-1:0] clr_reg;

    // Table
    logic [ENT_W-1:0]  mem [TABLE_SLOTS];
    logic [ENT_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;

    // Result register
    logic               m_valid_reg;
    logic [IDX_W-1:0]   m_slot_reg;
    logic [KEY_W-1:0]   m_key_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_new_reg;
    logic               m_full_reg;

    logic [CODE_W-1:0]  acc_shift;
    logic [CODE_W-1:0]  cp;
    logic               cp_done;
    logic               syl_ok;
    logic               end_pair;
    logic [TOK_W-1:0]   tok;
    logic [KEY_W-1:0]   hash;
    logic [KEY_W-1:0]   rd_key;
    logic [COUNT_W-1:0] rd_count;
    logic [COUNT_W-1:0] inc_count;
    logic               hit;
    logic               out_free;
    logic               feed_take;

    // ---------------- UTF-8 decoding ----------------
    assign acc_shift = {acc_reg[CODE_W-7:0], s_text_byte[5:0] & CONT_BITS[5:0]};
    assign tok       = TOK_W'(cp - SYL_FIRST);

    always_comb begin
        prev_tok_next = prev_tok_reg;
        wcnt_next     = wcnt_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        cp            = '0;
        cp_done       = 1'b0;
        end_pair      = 1'b0;
        syl_ok        = 1'b0;
        from_next     = prev_tok_reg;
        to_next       = TOKEN_BASE;
        priority if (s_text_byte == NEWLINE) begin
            // end the word, drop any pending sequence
            end_pair      = (wcnt_reg != '0);
            prev_tok_next = START_TOKEN;
            wcnt_next     = '0;
            rem_next      = '0;
            acc_next      = '0;
        end else if (rem_reg != 2'd0) begin
            acc_next = acc_shift;
            rem_next = rem_reg - 2'd1;
            if (rem_reg == 2'd1) begin
                cp_done = 1'b1;
                cp      = acc_shift;
            end
        end else if (!s_text_byte[7]) begin
            cp_done = 1'b1;
            cp      = CODE_W'(s_text_byte);
        end else if ((s_text_byte & LEAD2_MASK) == LEAD2_CODE) begin
            acc_next = CODE_W'(s_text_byte & LEAD2_BITS);
            rem_next = 2'd1;
        end else if ((s_text_byte & LEAD3_MASK) == LEAD3_CODE) begin
            acc_next = CODE_W'(s_text_byte & LEAD3_BITS);
            rem_next = 2'd2;
        end else begin
            acc_next = CODE_W'(s_text_byte & LEAD4_BITS);
            rem_next = 2'd3;
        end

        syl_ok = cp_done && (cp >= SYL_FIRST) && (cp <= SYL_LAST) && (wcnt_reg < WCNT_MAX);
        if (syl_ok) begin
            to_next       = tok + TOK_W'(1);
            prev_tok_next = tok;
            wcnt_next     = wcnt_reg + WCNT_W'(1);
        end
    end

    assign feed_take = cmd.take && (s_command == CMD_FEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tok_reg <= START_TOKEN;
            wcnt_reg     <= '0;
            rem_reg      <= '0;
            acc_reg      <= '0;
        end else if (feed_take) begin
            prev_tok_reg <= prev_tok_next;
            wcnt_reg     <= wcnt_next;
            rem_reg      <= rem_next;
            acc_reg      <= acc_next;
        end
    end

    // ---------------- Key, hash, probing ----------------
    assign hash = key_reg ^ (key_reg >> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_read_reg <= 1'b0;
            clr_reg     <= '0;
        end else begin
            if (cmd.take) begin
                is_read_reg <= (s_command == CMD_READ);
            end
            if (cmd.clear) begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            from_reg <= from_next;
            to_reg   <= to_next;
            addr_reg <= SLOT_W'(s_slot_index);
        end
        if (cmd.calc_key) begin
            key_reg <= KEY_W'(from_reg) * KEY_W'(TOKEN_BASE) + KEY_W'(to_reg);
        end
        if (cmd.start_probe) begin
            addr_reg  <= SLOT_W'(hash);
            home_reg  <= SLOT_W'(hash);
            probe_reg <= '0;
        end
        if (cmd.next_probe) begin
            addr_reg  <= addr_reg + SLOT_W'(1);
            probe_reg <= probe_reg + SLOT_W'(1);
        end
    end

    // ---------------- Table memory ----------------
    assign rd_key    = rd_data_reg[ENT_W-1:COUNT_W];
    assign rd_count  = rd_data_reg[COUNT_W-1:0];
    assign inc_count = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);
    assign hit       = (rd_key == '0) || (rd_key == key_reg);

    assign mem_we    = cmd.clear || (cmd.finish && !is_read_reg && hit);
    assign mem_waddr = cmd.clear ? clr_reg : addr_reg;
    assign mem_wdata = cmd.clear ? '0 : {key_reg, inc_count};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_mem) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // ---------------- Result register ----------------
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            priority if (is_read_reg) begin
                m_slot_reg  <= IDX_W'(addr_reg);
                m_key_reg   <= rd_key;
                m_count_reg <= rd_count;
                m_new_reg   <= 1'b0;
                m_full_reg  <= 1'b0;
            end else if (hit) begin
                m_slot_reg  <= IDX_W'(addr_reg);
                m_key_reg   <= key_reg;
                m_count_reg <= inc_count;
                m_new_reg   <= (rd_key == '0);
                m_full_reg  <= 1'b0;
            end else begin
                // every slot probed: report home slot, nothing stored
                m_slot_reg  <= IDX_W'(home_reg);
                m_key_reg   <= key_reg;
                m_count_reg <= '0;
                m_new_reg   <= 1'b0;
                m_full_reg  <= 1'b1;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot       = m_slot_reg;
    assign m_bigram_key = m_key_reg;
    assign m_pair_count = m_count_reg;
    assign m_new_entry  = m_new_reg;
    assign m_table_full = m_full_reg;

    // ---------------- Status ----------------
    always_comb begin
        sts            = '0;
        sts.clear_done = (clr_reg == '1);
        sts.job_read   = (s_command == CMD_READ);
        sts.job_bigram = end_pair || syl_ok;
        sts.is_read    = is_read_reg;
        sts.hit        = hit;
        sts.last_probe = (probe_reg == '1);
        sts.out_free   = out_free;
    end

endmodule

@@ src/hangul_bigram_hash_counter.sv @@
// Sequence: a byte that forms no bigram is only accepted; a slot read goes from
// acceptance through the table read to the result register; a bigram forms its key,
// hashes it, then reads and compares each probed slot until a usable one or the table end.
// Throughput: one request at a time; the table memory port sets the probe rate.
// Reset: synchronous, active low; afterwards every table slot is cleared before
// the first request is accepted.
// ----------------------------------------------------------------------------
// hangul_bigram_hash_counter
// UTF-8 Hangul bigram counter with an open-addressed linear-probe hash table.
// ----------------------------------------------------------------------------
module hangul_bigram_hash_counter
    import hbc_pkg::*;
#(
    parameter int TABLE_SLOTS        = DEF_TABLE_SLOTS,
    parameter int MAX_WORD_SYLLABLES = DEF_MAX_WORD_SYLLABLES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_command,
    input  logic [BYTE_W-1:0]  s_text_byte,
    input  logic [IDX_W-1:0]   s_slot_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [IDX_W-1:0]   m_slot,
    output logic [KEY_W-1:0]   m_bigram_key,
    output logic [COUNT_W-1:0] m_pair_count,
    output logic               m_new_entry,
    output logic               m_table_full
);

    cmd_t cmd;
    sts_t sts;

    hbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hbc_datapath #(
        .TABLE_SLOTS        (TABLE_SLOTS),
        .MAX_WORD_SYLLABLES (MAX_WORD_SYLLABLES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_command    (s_command),
        .s_text_byte  (s_text_byte),
        .s_slot_index (s_slot_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot       (m_slot),
        .m_bigram_key (m_bigram_key),
        .m_pair_count (m_pair_count),
        .m_new_entry  (m_new_entry),
        .m_table_full (m_table_full)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hangul bigram hash counter testbench
// Feeds UTF-8 text bytes and slot reads with random gaps, stalls the result
// side at random, and checks every result against a predictor of the
// decoder, the word tracking and the linear-probe table.
// ----------------------------------------------------------------------------

class bigram_tally;
    typedef struct packed {
        logic [hbc_pkg::IDX_W-1:0]   slot;
        logic [hbc_pkg::KEY_W-1:0]   key;
        logic [hbc_pkg::COUNT_W-1:0] count;
        logic                        fresh;
        logic                        full;
    } slot_result_t;

    logic [hbc_pkg::KEY_W-1:0]   key_at[int unsigned];
    logic [hbc_pkg::COUNT_W-1:0] count_at[int unsigned];
    logic [hbc_pkg::TOK_W-1:0]   prev_tok;
    int unsigned                 word_len;
    int unsigned                 cont_left;
    logic [hbc_pkg::CODE_W-1:0]  code_acc;
    slot_result_t                due_results[$];
    int unsigned                 filled_slots[$];
    int                          mismatches;

    function new();
        prev_tok   = hbc_pkg::START_TOKEN;
        word_len   = 0;
        cont_left  = 0;
        code_acc   = '0;
        mismatches = 0;
    endfunction

    static function int unsigned bigram_key(int unsigned from_tok, int unsigned to_tok);
        int unsigned base;
        base = hbc_pkg::TOKEN_BASE;
        return from_tok * base + to_tok + 1;
    endfunction

    static function int unsigned home_slot(int unsigned k);
        return (k ^ (k >> 16)) % hbc_pkg::DEF_TABLE_SLOTS;
    endfunction

    function void count_pair(int unsigned k);
        int unsigned  home;
        int unsigned  h;
        int unsigned  n;
        slot_result_t r;
        home  = home_slot(k);
        h     = home;
        r.key = k[hbc_pkg::KEY_W-1:0];
        for (n = 0; n < hbc_pkg::DEF_TABLE_SLOTS; n++) begin
            if (!key_at.exists(h) || key_at[h] == k) begin
                r.slot  = h[hbc_pkg::IDX_W-1:0];
                r.fresh = !key_at.exists(h);
                r.full  = 1'b0;
                r.count = count_at.exists(h) ? count_at[h] : '0;
                if (r.count != '1)
                    r.count = r.count + 1'b1;
                if (r.fresh)
                    filled_slots.push_back(h);
                key_at[h]   = r.key;
                count_at[h] = r.count;
                due_results.push_back(r);
                return;
            end
            h = (h + 1) % hbc_pkg::DEF_TABLE_SLOTS;
        end
        // every slot taken by another key: report the home slot, touch nothing
        r.slot  = home[hbc_pkg::IDX_W-1:0];
        r.count = '0;
        r.fresh = 1'b0;
        r.full  = 1'b1;
        due_results.push_back(r);
    endfunction

    function void take_code_point(int unsigned cp);
        int unsigned tok;
        if (cp < hbc_pkg::SYL_FIRST || cp > hbc_pkg::SYL_LAST)
            return;
        // syllables past the word limit are dropped
        if (word_len >= hbc_pkg::DEF_MAX_WORD_SYLLABLES)
            return;
        tok = cp - hbc_pkg::SYL_FIRST;
        count_pair(bigram_key(32'(prev_tok), tok));
        prev_tok = tok[hbc_pkg::TOK_W-1:0];
        word_len++;
    endfunction

    function void note_request(logic [hbc_pkg::CMD_W-1:0] cmd,
                               logic [hbc_pkg::BYTE_W-1:0] b,
                               logic [hbc_pkg::IDX_W-1:0] idx);
        slot_result_t r;
        int unsigned  s;
        if (cmd == hbc_pkg::CMD_READ) begin
            s       = idx % hbc_pkg::DEF_TABLE_SLOTS;
            r.slot  = s[hbc_pkg::IDX_W-1:0];
            r.key   = key_at.exists(s) ? key_at[s] : '0;
            r.count = count_at.exists(s) ? count_at[s] : '0;
            r.fresh = 1'b0;
            r.full  = 1'b0;
            due_results.push_back(r);
            return;
        end
        if (b == hbc_pkg::NEWLINE) begin
            if (word_len > 0)
                count_pair(bigram_key(32'(prev_tok), 32'(hbc_pkg::END_TOKEN)));
            prev_tok  = hbc_pkg::START_TOKEN;
            word_len  = 0;
            cont_left = 0;
            code_acc  = '0;
            return;
        end
        if (cont_left > 0) begin
            code_acc  = (code_acc << 6) | (b & hbc_pkg::CONT_BITS);
            cont_left = cont_left - 1;
            if (cont_left == 0)
                take_code_point(32'(code_acc));
            return;
        end
        if (!b[7]) begin
            take_code_point(32'(b));
        end else if ((b & hbc_pkg::LEAD2_MASK) == hbc_pkg::LEAD2_CODE) begin
            code_acc  = {{(hbc_pkg::CODE_W - hbc_pkg::BYTE_W){1'b0}}, b & hbc_pkg::LEAD2_BITS};
            cont_left = 1;
        end else if ((b & hbc_pkg::LEAD3_MASK) == hbc_pkg::LEAD3_CODE) begin
            code_acc  = {{(hbc_pkg::CODE_W - hbc_pkg::BYTE_W){1'b0}}, b & hbc_pkg::LEAD3_BITS};
            cont_left = 2;
        end else begin
            // any other lead, stray continuations included, opens four bytes
            code_acc  = {{(hbc_pkg::CODE_W - hbc_pkg::BYTE_W){1'b0}}, b & hbc_pkg::LEAD4_BITS};
            cont_left = 3;
        end
    endfunction

    function void check_result(slot_result_t got);
        slot_result_t want;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result slot=%0d key=%0d count=%0d new=%0b full=%0b",
                         got.slot, got.key, got.count, got.fresh, got.full);
            return;
        end
        want = due_results.pop_front();
        if (got.slot !== want.slot || got.key !== want.key || got.count !== want.count ||
            got.fresh !== want.fresh || got.full !== want.full) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("ERROR: expected slot=%0d key=%0d count=%0d new=%0b full=%0b,",
                       want.slot, want.key, want.count, want.fresh, want.full);
                $display(" got slot=%0d key=%0d count=%0d new=%0b full=%0b",
                         got.slot, got.key, got.count, got.fresh, got.full);
            end
        end
    endfunction
endclass

module tb;
    import hbc_pkg::*;

    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          RANDOM_ITEMS = 800;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          LONG_WORD    = DEF_MAX_WORD_SYLLABLES + 4;
    localparam int unsigned LAST_TOK     = SYL_LAST - SYL_FIRST;
    localparam logic [BYTE_W-1:0] CONT_TAG = 8'h80;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [CMD_W-1:0]   s_command;
    logic [BYTE_W-1:0]  s_text_byte;
    logic [IDX_W-1:0]   s_slot_index;
    logic               m_valid;
    logic               m_ready;
    logic [IDX_W-1:0]   m_slot;
    logic [KEY_W-1:0]   m_bigram_key;
    logic [COUNT_W-1:0] m_pair_count;
    logic               m_new_entry;
    logic               m_table_full;

    bigram_tally tally;
    int unsigned cycle_count;
    int unsigned sent_count;
    bit          hold_off_due;
    int          send_calm_left;
    int unsigned common_toks[8];

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    hangul_bigram_hash_counter #(
        .TABLE_SLOTS        (DEF_TABLE_SLOTS),
        .MAX_WORD_SYLLABLES (DEF_MAX_WORD_SYLLABLES)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_text_byte  (s_text_byte),
        .s_slot_index (s_slot_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot       (m_slot),
        .m_bigram_key (m_bigram_key),
        .m_pair_count (m_pair_count),
        .m_new_entry  (m_new_entry),
        .m_table_full (m_table_full)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_token();
        if ($urandom_range(0, 4) != 0)
            return common_toks[$urandom_range(0, 7)];
        return $urandom_range(0, LAST_TOK);
    endfunction

    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                            input logic [IDX_W-1:0] idx);
        int gap;
        if (send_calm_left > 0) begin
            gap = 0;
            send_calm_left--;
        end else if ($urandom_range(0, 99) < 3) begin
            gap = 0;
            send_calm_left = $urandom_range(30, 200);
        end else begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_text_byte  <= b;
        s_slot_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tally.note_request(cmd, b, idx);
        sent_count++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_req(CMD_FEED, b, IDX_W'($urandom_range(0, 65535)));
    endtask

    task automatic send_syllable(input int unsigned tok);
        logic [IDX_W-1:0] cp;
        cp = IDX_W'(SYL_FIRST + tok);
        send_byte(LEAD3_CODE | cp[15:12]);
        send_byte(CONT_TAG | cp[11:6]);
        send_byte(CONT_TAG | cp[5:0]);
    endtask

    task automatic send_word(input int n, input bit tidy);
        int i;
        for (i = 0; i < n; i++) begin
            // stray code points inside a word leave the bigram chain alone
            if (!tidy && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_byte(BYTE_W'($urandom_range(32, 126)));
                    1: begin
                        send_byte(LEAD2_CODE | BYTE_W'($urandom_range(0, 31)));
                        send_byte(CONT_TAG | BYTE_W'($urandom_range(0, 63)));
                    end
                    default: send_byte(8'h00);
                endcase
            end
            send_syllable(pick_token());
        end
        send_byte(NEWLINE);
    endtask

    task automatic send_key_word(input int unsigned k);
        int unsigned from_tok;
        int unsigned to_tok;
        from_tok = (k - 1) / TOKEN_BASE;
        to_tok   = (k - 1) % TOKEN_BASE;
        if (from_tok != START_TOKEN)
            send_syllable(from_tok);
        send_syllable(to_tok);
        send_byte(NEWLINE);
    endtask

    task automatic send_read();
        int unsigned s;
        if (tally.filled_slots.size() > 0 && $urandom_range(0, 9) < 7)
            s = tally.filled_slots[$urandom_range(0, tally.filled_slots.size() - 1)];
        else
            s = $urandom_range(0, DEF_TABLE_SLOTS - 1);
        send_req(CMD_READ, BYTE_W'($urandom_range(0, 255)), IDX_W'(s));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 0) begin
            repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
            // cut a sequence short with a newline
            send_byte(LEAD3_CODE | BYTE_W'($urandom_range(0, 15)));
            if (n > 3)
                send_byte(CONT_TAG | BYTE_W'($urandom_range(0, 63)));
            send_byte(NEWLINE);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tally.check_result({m_slot, m_bigram_key, m_pair_count, m_new_entry, m_table_full});
    end

    initial begin : result_sink
        int stall_left;
        int calm_left;
        int held;
        stall_left = 0;
        calm_left  = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_due) begin
                // hold results back so the block fills and stalls its input
                hold_off_due = 1'b0;
                m_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) < 4)
                    calm_left = $urandom_range(50, 300);
                else
                    stall_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned seen_home[int unsigned];
        int unsigned key_a;
        int unsigned key_b;
        int unsigned k;
        int unsigned h;
        int unsigned src_pick;
        int unsigned t;
        int          r;
        int          n;
        bit          long_done;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_command    <= CMD_FEED;
        s_text_byte  <= '0;
        s_slot_index <= '0;
        tally          = new();
        sent_count     = 0;
        hold_off_due   = 1'b0;
        send_calm_left = 0;
        common_toks[0] = 0;
        common_toks[1] = LAST_TOK;
        for (int i = 2; i < 8; i++)
            common_toks[i] = $urandom_range(0, LAST_TOK);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty slots at both ends, then a newline with no word open
        send_req(CMD_READ, 8'h00, 16'h0000);
        send_req(CMD_READ, 8'hFF, 16'hFFFF);
        send_byte(NEWLINE);
        // first and last syllable in one word
        send_syllable(0);
        send_syllable(LAST_TOK);
        send_byte(NEWLINE);
        // zero byte, ASCII, a two-byte letter, a four-byte run off an 0xFF lead
        send_byte(8'h00);
        send_byte(8'h61);
        send_byte(8'hC3);
        send_byte(8'hA9);
        send_byte(8'hFF);
        repeat (3) send_byte(CONT_TAG);
        // continuation bits are taken unchecked: this still decodes to U+AC00
        send_byte(8'hEA);
        send_byte(8'hF0);
        send_byte(CONT_TAG);
        // newline drops the half-done sequence and closes the word
        send_byte(8'hEA);
        send_byte(8'hB0);
        send_byte(NEWLINE);

        // find two bigrams that share a home slot to force a probe
        key_a = 0;
        key_b = 0;
        for (src_pick = 0; src_pick <= 8 && key_b == 0; src_pick++) begin
            for (t = 0; t <= LAST_TOK && key_b == 0; t++) begin
                k = tally.bigram_key(src_pick == 0 ? START_TOKEN : src_pick - 1, t);
                h = tally.home_slot(k);
                if (seen_home.exists(h)) begin
                    key_a = seen_home[h];
                    key_b = k;
                end else begin
                    seen_home[h] = k;
                end
            end
        end
        if (key_b != 0) begin
            send_key_word(key_a);
            send_key_word(key_b);
            send_key_word(key_b);
        end

        hold_off_due = 1'b1;
        long_done    = 1'b0;
        while (sent_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
                send_word(n, $urandom_range(0, 3) != 0);
            end else if (r < 85) begin
                send_read();
            end else begin
                send_noise();
            end
            // the over-long word alone is most of the item budget
            if (!long_done && sent_count >= RANDOM_ITEMS / 8) begin
                send_word(LONG_WORD, 1'b1);
                long_done = 1'b1;
            end
        end
        s_valid <= 1'b0;

        while (tally.due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tally.mismatches == 0 && tally.due_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/hbc_pkg.sv
src/hbc_ctrl.sv
src/hbc_datapath.sv
src/hangul_bigram_hash_counter.sv
tb/sv/tb.sv
